FILE: rtl/core/rspv_pkg.sv
// Package for the sample playback voice: request codes, widths, shared types.
// No dependencies.
`default_nettype none
package rspv_pkg;
  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_PLAY   = 3'd1;
  localparam logic [2:0] REQ_PAUSE  = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_RENDER = 3'd4;

  localparam logic [2:0] CFG_FRAMES   = 3'd0;
  localparam logic [2:0] CFG_CHANNELS = 3'd1;
  localparam logic [2:0] CFG_STEP     = 3'd2;
  localparam logic [2:0] CFG_LOOP     = 3'd3;
  localparam logic [2:0] CFG_SPATIAL  = 3'd4;
  localparam logic [2:0] CFG_LGAIN    = 3'd5;
  localparam logic [2:0] CFG_RGAIN    = 3'd6;
  localparam logic [2:0] CFG_OUTCH    = 3'd7;

  localparam int POS_W = 34;
  localparam int ACC_W = 40;   // sum of up to 32 interpolated values
  localparam int NUM_W = 57;   // accumulator times 16-bit gain, plus one

  typedef struct packed {
    logic               start;
    logic signed [NUM_W-1:0] num;
    logic [5:0]         nch;    // divisor is nch * 2^shift
    logic [4:0]         shift;  // 28 or 29
  } rspv_div_req_t;
endpackage
`default_nettype wire

FILE: rtl/core/rspv_div.sv
// Serial rounding divider: |num| + d/2 over d, one quotient bit a cycle.
// Depends on rspv_pkg.
`default_nettype none
module rspv_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rspv_pkg::rspv_div_req_t req,
  output logic                      done,
  output logic signed [15:0]        quo
);
  localparam int NW = rspv_pkg::NUM_W;
  logic [NW-1:0] rem, den;
  logic [16:0]   q;
  logic [4:0]    cnt;
  logic          busy, neg;
  logic [NW-1:0] mag, dfull, trial;

  always_comb begin
    mag   = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    dfull = NW'(req.nch) << req.shift;
    trial = den << cnt;
  end

  // quotient saturates at 17 bits; quotients of 65536 or more saturate anyway
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        neg  <= req.num[NW-1];
        den  <= dfull;
        rem  <= mag + (dfull >> 1);
        q    <= '0;
        cnt  <= 5'd16;
      end else if (busy) begin
        if ((rem >> cnt) >= den) begin
          rem <= rem - trial;
          q   <= q | (17'd1 << cnt);
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_comb begin
    if (neg) quo = (q > 17'd32768) ? 16'sh8000 : 16'(-q);
    else     quo = (q > 17'd32767) ? 16'sh7FFF : 16'(q);
  end
endmodule
`default_nettype wire

FILE: rtl/core/resampling_sample_playback_voice.sv
// Sample playback voice with linear interpolation and gains, one request in flight.
// A playing render runs a setup state, two reads per fetched channel (2*nch in spatial
// mode, else 2 or 4), a multiply state, then a serial divide and emit per output channel;
// a loop wrap first runs a shifted-subtraction state before the setup.
// A stopped render emits one zero per cycle while out_ready is high; others finish on accept.
// Reset (synchronous, rst high) clears play flag, position and registers; memory keeps data.
`default_nettype none
module resampling_sample_playback_voice #(
  parameter int SAMPLE_WORDS = 65536,
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         req_type,
  input  wire logic [15:0]        sample_addr,
  input  wire logic signed [15:0] sample_value,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      sample_out,
  output logic [2:0]              out_channel,
  output logic                    last_of_frame,
  output logic                    playing_now,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int PW = rspv_pkg::POS_W;
  localparam int AC = rspv_pkg::ACC_W;
  localparam int WW = PW + 18;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PREP  = 8'b00000010,
    S_READ  = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_WAIT  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_WRAP  = 8'b10000000
  } state_t;

  // configuration registers
  logic [16:0] clip_frames;
  logic [3:0]  clip_channels, out_channels;
  logic [31:0] step_increment;
  logic        loop_enable, spatial_mode;
  logic [15:0] gain_l, gain_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_frames <= 17'd1; clip_channels <= 4'd1; step_increment <= 32'd65536;
      loop_enable <= 1'b0; spatial_mode <= 1'b0; gain_l <= 16'd4096;
      gain_r <= 16'd4096; out_channels <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        rspv_pkg::CFG_FRAMES:   clip_frames <= cfg_data[16:0];
        rspv_pkg::CFG_CHANNELS: clip_channels <= cfg_data[3:0];
        rspv_pkg::CFG_STEP:     step_increment <= cfg_data;
        rspv_pkg::CFG_LOOP:     loop_enable <= cfg_data[0];
        rspv_pkg::CFG_SPATIAL:  spatial_mode <= cfg_data[0];
        rspv_pkg::CFG_LGAIN:    gain_l <= cfg_data[15:0];
        rspv_pkg::CFG_RGAIN:    gain_r <= cfg_data[15:0];
        rspv_pkg::CFG_OUTCH:    out_channels <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sample memory: one write port, one registered read port
  logic [15:0] mem [SAMPLE_WORDS];
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          mem_we;
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(sample_addr)] <= sample_value;
    rd_data <= mem[rd_addr];
  end

  state_t state;
  logic [PW-1:0] pos;
  logic          playing, active;
  logic [CW-1:0] nch;
  logic [3:0]    nout, k;
  logic [16:0]   frames;
  logic [31:0]   step;
  logic [16:0]   f0, f1;
  logic [15:0]   t;
  logic [CW-1:0] ch;
  logic          rsel;   // 0 reads frame f0, 1 reads frame f1
  logic          rdv;    // rd_data holds valid read data
  logic          rdv_sel, rdv_oob;
  logic [CW-1:0] rdv_ch;
  logic signed [16:0] a_val;
  logic signed [AC-1:0] acc_l, acc_r;
  logic signed [rspv_pkg::NUM_W-1:0] nl, nr;
  logic [1:0]    mphase;
  logic [PW-1:0] endp;
  logic [37:0]   idx;
  rspv_pkg::rspv_div_req_t dreq;
  logic          ddone;
  logic signed [15:0] dq;
  logic signed [16:0] bval;
  logic signed [AC-1:0] lerp_v;
  logic [4:0]    wsh;     // wrap shift, one quotient bit of pos / endp a cycle
  logic [WW-1:0] wtrial;

  always_comb begin
    nout   = (out_channels == 4'd0) ? 4'd2 : (out_channels > 4'd8 ? 4'd8 : out_channels);
    frames = (clip_frames > 17'd65536) ? 17'd65536 : clip_frames;
    step   = (step_increment < 32'd7) ? 32'd7 : step_increment;
    endp   = PW'(frames) << 16;
    wtrial = WW'(endp) << wsh;
    idx    = 38'(rsel ? f1 : f0) * 38'(nch) + 38'(ch);
    bval   = rdv_oob ? 17'sd0 : 17'(signed'(rd_data));
    lerp_v = AC'(a_val) * AC'(65536) + (AC'(bval) - AC'(a_val)) * AC'(signed'({1'b0, t}));
  end

  // the output register holds a waiting result, so the input stays open meanwhile
  assign in_ready = (state == S_IDLE);
  assign mem_we   = in_valid && in_ready && req_type == rspv_pkg::REQ_WRITE
                    && 32'(sample_addr) < 32'(SAMPLE_WORDS);
  assign rd_addr  = AW'(idx);

  // divider request: output 0 is left, 1 is right, others (or a lone output) the mean of both
  always_comb begin
    dreq.start = (state == S_DIV);
    dreq.nch   = spatial_mode ? 6'(nch) : 6'd1;
    if (nout == 4'd1 || k >= 4'd2) begin
      dreq.num = nl + nr; dreq.shift = 5'd29;
    end else begin
      dreq.num = (k == 4'd0) ? nl : nr; dreq.shift = 5'd28;
    end
  end

  rspv_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pos <= '0; playing <= 1'b0; out_valid <= 1'b0;
      rdv <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      rdv <= (state == S_READ);
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          case (req_type)
            rspv_pkg::REQ_PLAY:  begin if (restart) pos <= '0; playing <= 1'b1; end
            rspv_pkg::REQ_PAUSE: playing <= 1'b0;
            rspv_pkg::REQ_STOP:  begin playing <= 1'b0; pos <= '0; end
            rspv_pkg::REQ_RENDER: begin
              k <= '0; active <= 1'b0;
              nch <= (clip_channels == 4'd0) ? CW'(1) :
                     (32'(clip_channels) > 32'(MAX_CHANNELS) ? CW'(MAX_CHANNELS)
                                                             : CW'(clip_channels));
              if (!playing) state <= S_EMIT;
              else if (frames == 17'd0) begin
                playing <= 1'b0; pos <= '0; state <= S_EMIT;
              end else if (pos >= endp) begin
                if (loop_enable) begin state <= S_WRAP; wsh <= 5'd17; end
                else begin playing <= 1'b0; pos <= endp; state <= S_EMIT; end
              end else state <= S_PREP;
            end
            default: ;
          endcase
        end
        // wrap by shifted subtraction: at most 2^18 laps, one bit a cycle
        S_WRAP: begin
          if (WW'(pos) >= wtrial) pos <= pos - PW'(wtrial);
          if (wsh == 5'd0) state <= S_PREP;
          else wsh <= wsh - 5'd1;
        end
        S_PREP: begin
          f0 <= pos[32:16];
          t  <= (!loop_enable && pos[32:16] + 17'd1 >= frames) ? '0 : pos[15:0];
          if (loop_enable) f1 <= (pos[32:16] + 17'd1 == frames) ? 17'd0 : pos[32:16] + 17'd1;
          else if (pos[32:16] + 17'd1 >= frames) f1 <= pos[32:16];
          else f1 <= pos[32:16] + 17'd1;
          ch <= '0; rsel <= 1'b0; acc_l <= '0; acc_r <= '0;
          active <= 1'b1;
          state <= S_READ;
        end
        S_READ: begin
          // issue reads f0 then f1 for each fetched channel; accumulate on return
          rdv_sel <= rsel; rdv_ch <= ch;
          rdv_oob <= idx >= 38'(SAMPLE_WORDS);
          if (rsel) begin
            rsel <= 1'b0;
            if (spatial_mode ? (ch == nch - CW'(1)) : (ch != '0 || nch == CW'(1)))
              state <= S_MUL;
            else ch <= ch + CW'(1);
          end else rsel <= 1'b1;
          if (rdv && !rdv_sel) a_val <= rdv_oob ? 17'sd0 : 17'(signed'(rd_data));
          mphase <= 2'd0;
        end
        S_MUL: begin
          if (rdv && !rdv_sel) a_val <= rdv_oob ? 17'sd0 : 17'(signed'(rd_data));
          mphase <= mphase + 2'd1;
          if (mphase == 2'd1) begin
            nl <= acc_l * signed'({1'b0, gain_l});
            nr <= (spatial_mode || nch == CW'(1) ? acc_l : acc_r)
                  * signed'({1'b0, gain_r});
            pos <= pos + PW'(step);
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (ddone) state <= S_EMIT;
        S_EMIT: if (!out_valid || out_ready) begin
          out_valid     <= 1'b1;
          sample_out    <= active ? dq : 16'sd0;
          out_channel   <= k[2:0];
          last_of_frame <= (k + 4'd1 == nout);
          playing_now   <= playing;
          if (k + 4'd1 == nout) state <= S_IDLE;
          else begin k <= k + 4'd1; state <= active ? S_DIV : S_EMIT; end
        end
        default: state <= S_IDLE;
      endcase
      // returned f1 completes one channel's interpolation
      if (rdv && rdv_sel) begin
        if (spatial_mode || rdv_ch == '0) acc_l <= acc_l + lerp_v;
        else acc_r <= lerp_v;
        if (!spatial_mode && rdv_ch == '0 && nch == CW'(1)) acc_r <= lerp_v;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    ddone |-> (state == S_WAIT)) else $error("divider done out of place");
  a_pause_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == rspv_pkg::REQ_PAUSE) |=> !playing)
    else $error("pause kept flag");
`endif
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for resampling_sample_playback_voice.
// Depends on rspv_pkg and the voice RTL; a scoreboard class predicts each
// rendered frame and checks every output transaction in order.
`timescale 1ns / 1ps

module tb_top;
  // Request codes above render; the block must ignore them.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int IDLE_LIMIT  = 5000;   // cycles with no transaction at all
  localparam int DRAIN_WAIT  = 300;    // longest render plus margin
  localparam int HOLD_CYCLES = 600;    // long receiver hold-off

  // Predicts the voice: its own copy of sample memory, position, play flag
  // and registers. Expected output transactions queue up in order.
  class voice_scoreboard;
    typedef struct {
      logic signed [15:0] value;
      logic [2:0]         chan;
      logic               last;
      logic               playing;
    } voice_result_t;

    voice_result_t expected_q[$];
    logic [15:0] mem [0:65535];
    logic [33:0] position;
    bit          playing;
    logic [16:0] frames_r;
    logic [3:0]  chans_r;
    logic [31:0] step_r;
    bit          loop_r;
    bit          spatial_r;
    logic [15:0] lgain_r;
    logic [15:0] rgain_r;
    logic [3:0]  outch_r;
    int          errors;

    function new();
      foreach (mem[i]) mem[i] = '0;
      position = '0;
      playing = 0;
      frames_r = 17'd1;
      chans_r = 4'd1;
      step_r = 32'd65536;
      loop_r = 0;
      spatial_r = 0;
      lgain_r = 16'd4096;
      rgain_r = 16'd4096;
      outch_r = 4'd2;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        rspv_pkg::CFG_FRAMES:   frames_r = data[16:0];
        rspv_pkg::CFG_CHANNELS: chans_r = data[3:0];
        rspv_pkg::CFG_STEP:     step_r = data;
        rspv_pkg::CFG_LOOP:     loop_r = data[0];
        rspv_pkg::CFG_SPATIAL:  spatial_r = data[0];
        rspv_pkg::CFG_LGAIN:    lgain_r = data[15:0];
        rspv_pkg::CFG_RGAIN:    rgain_r = data[15:0];
        rspv_pkg::CFG_OUTCH:    outch_r = data[3:0];
        default: ;
      endcase
    endfunction

    function longint sample_at(longint frame, int ch, int nch);
      longint idx;
      if (ch > nch - 1) ch = nch - 1;
      idx = frame * nch + ch;
      if (idx >= 65536) return 0;
      return longint'($signed(mem[idx]));
    endfunction

    // a*2^16 + (b-a)*t for one channel between two clip frames
    function longint interp(longint f0, longint f1, longint t, int ch, int nch);
      longint a;
      longint b;
      a = sample_at(f0, ch, nch);
      b = sample_at(f1, ch, nch);
      return a * 65536 + (b - a) * t;
    endfunction

    // round half away from zero, then clamp to Q1.15
    function logic [15:0] round_sat(longint n, longint d);
      longint q;
      if (n >= 0) q = (n + d / 2) / d;
      else q = -((-n + d / 2) / d);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_input(logic [2:0] req, logic [15:0] addr, logic [15:0] val,
                             logic rs);
      int nout;
      int nch;
      longint nframes;
      longint stride;
      longint span;
      longint f0;
      longint f1;
      longint t;
      longint acc;
      longint nl;
      longint nr;
      longint den;
      bit active;
      voice_result_t r;
      nl = 0;
      nr = 0;
      den = 64'd268435456;
      active = 0;
      case (req)
        rspv_pkg::REQ_WRITE: begin
          mem[addr] = val;
          return;
        end
        rspv_pkg::REQ_PLAY: begin
          if (rs) position = '0;
          playing = 1;
          return;
        end
        rspv_pkg::REQ_PAUSE: begin
          playing = 0;
          return;
        end
        rspv_pkg::REQ_STOP: begin
          playing = 0;
          position = '0;
          return;
        end
        rspv_pkg::REQ_RENDER: ;
        default: return;
      endcase

      // effective register values after saturation
      nout = (outch_r == 0) ? 2 : ((outch_r > 8) ? 8 : int'(outch_r));
      nch = (chans_r == 0) ? 1 : ((chans_r > 8) ? 8 : int'(chans_r));
      nframes = (frames_r > 17'd65536) ? 65536 : longint'(frames_r);
      stride = (step_r < 7) ? 7 : longint'(step_r);

      if (playing) begin
        if (nframes == 0) begin
          playing = 0;
          position = '0;
        end else begin
          span = nframes << 16;
          if (longint'(position) >= span) begin
            if (loop_r) position = 34'(longint'(position) % span);
            else begin
              playing = 0;
              position = 34'(span);
            end
          end
          if (playing) begin
            f0 = longint'(position >> 16);
            t = longint'(position[15:0]);
            if (loop_r) f1 = (f0 + 1) % nframes;
            else if (f0 + 1 >= nframes) begin
              f1 = f0;
              t = 0;
            end else f1 = f0 + 1;
            if (spatial_r) begin
              acc = 0;
              for (int c = 0; c < nch; c++) acc += interp(f0, f1, t, c, nch);
              nl = acc * longint'(lgain_r);
              nr = acc * longint'(rgain_r);
              den = longint'(nch) * 268435456;
            end else begin
              nl = interp(f0, f1, t, 0, nch) * longint'(lgain_r);
              nr = interp(f0, f1, t, (nch > 1) ? 1 : 0, nch) * longint'(rgain_r);
            end
            position = position + 34'(stride);
            active = 1;
          end
        end
      end

      for (int k = 0; k < nout; k++) begin
        r.value = '0;
        if (active) begin
          if (nout == 1 || k >= 2) r.value = round_sat(nl + nr, 2 * den);
          else if (k == 0) r.value = round_sat(nl, den);
          else r.value = round_sat(nr, den);
        end
        r.chan = k[2:0];
        r.last = (k + 1 == nout);
        r.playing = playing;
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_result(logic [15:0] value, logic [2:0] chan, logic last,
                               logic play_bit);
      voice_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output value=%0d chan=%0d", $signed(value), chan));
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value)
        report($sformatf("sample_out %0d, want %0d (chan %0d)", $signed(value),
                         e.value, e.chan));
      if (chan !== e.chan)
        report($sformatf("out_channel %0d, want %0d", chan, e.chan));
      if (last !== e.last)
        report($sformatf("last_of_frame %0b, want %0b (chan %0d)", last, e.last, e.chan));
      if (play_bit !== e.playing)
        report($sformatf("playing_now %0b, want %0b (chan %0d)", play_bit, e.playing,
                         e.chan));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = rspv_pkg::REQ_WRITE;
  logic [15:0] sample_addr = '0;
  logic signed [15:0] sample_value = '0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] sample_out;
  logic [2:0]  out_channel;
  logic        last_of_frame;
  logic        playing_now;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = rspv_pkg::CFG_FRAMES;
  logic [31:0] cfg_data = '0;

  voice_scoreboard sb = new();
  bit quiet_send = 0;      // sender offers back to back while set
  bit hold_request = 0;    // ask the receiver for one long hold-off
  int idle_cycles = 0;

  resampling_sample_playback_voice uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .sample_addr(sample_addr),
    .sample_value(sample_value), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_out(sample_out), .out_channel(out_channel),
    .last_of_frame(last_of_frame), .playing_now(playing_now),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: check each output transaction, then draw a stall for the next.
  // Stretches with no stall at all alternate with random stalls.
  int  stall_left = 0;
  bit  quiet_recv = 0;
  int  recv_cycle = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    int next_stall;
    next_stall = stall_left;
    recv_cycle <= recv_cycle + 1;
    if (recv_cycle % 128 == 0) quiet_recv <= ($urandom_range(0, 2) == 0);
    if (!rst && out_valid && out_ready) begin
      sb.check_result(sample_out, out_channel, last_of_frame, playing_now);
      next_stall = quiet_recv ? 0 : $urandom_range(0, 17);
    end else if (next_stall > 0) begin
      next_stall--;
    end
    // one long hold-off while a result waits and the sender keeps offering,
    // so the block fills up and blocks its input
    if (hold_request && !hold_done && in_valid && out_valid) begin
      next_stall = HOLD_CYCLES;
      hold_done <= 1;
    end
    stall_left <= next_stall;
    out_ready <= (next_stall == 0);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("resampling_sample_playback_voice regression: fail");
      $finish;
    end
  end

  // Offer one input transaction after a random gap; hold valid and payload
  // until accepted. Valid stays high into the next item when its gap is zero.
  task automatic send_item(logic [2:0] req, logic [15:0] addr, logic [15:0] val,
                           logic rs);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    sample_addr <= addr;
    sample_value <= val;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req, addr, val, rs);
  endtask

  // Drain every expected result, then let any write or control item finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  function automatic logic [15:0] clip_value();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One phase: program all registers, rewind, load the clip, start playing,
  // then a random mix of renders, writes, transport requests and ignored codes.
  // A wide clip only loads its first frames; with a unit step and few
  // renders the position never reaches past them.
  task automatic run_phase(logic [16:0] frames, logic [3:0] chans, logic [31:0] step,
                           bit lp, bit sp, logic [15:0] lg, logic [15:0] rg,
                           logic [3:0] och, int items, bit wide);
    int nch;
    int words;
    int r;
    wait_idle();
    set_reg(rspv_pkg::CFG_FRAMES, 32'(frames));
    set_reg(rspv_pkg::CFG_CHANNELS, 32'(chans));
    set_reg(rspv_pkg::CFG_STEP, step);
    set_reg(rspv_pkg::CFG_LOOP, 32'(lp));
    set_reg(rspv_pkg::CFG_SPATIAL, 32'(sp));
    set_reg(rspv_pkg::CFG_LGAIN, 32'(lg));
    set_reg(rspv_pkg::CFG_RGAIN, 32'(rg));
    set_reg(rspv_pkg::CFG_OUTCH, 32'(och));
    cfg_we <= 1'b0;
    quiet_send = ($urandom_range(0, 3) == 0);
    nch = (chans == 0) ? 1 : ((chans > 8) ? 8 : int'(chans));
    words = wide ? (items + 4) * nch
                 : ((frames > 17'd65536) ? 65536 : int'(frames)) * nch;
    send_item(rspv_pkg::REQ_STOP, '0, '0, 1'b0);
    for (int i = 0; i < words; i++)
      send_item(rspv_pkg::REQ_WRITE, 16'(i), clip_value(), 1'b0);
    send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b1);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(rspv_pkg::REQ_RENDER, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 70 && words > 0)
        send_item(rspv_pkg::REQ_WRITE, 16'($urandom_range(0, words - 1)), clip_value(),
                  1'b0);
      else if (r < 75 && !wide)
        send_item(rspv_pkg::REQ_WRITE, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 80) send_item(rspv_pkg::REQ_PLAY, 16'($urandom), '0, 1'($urandom));
      else if (r < 85) send_item(rspv_pkg::REQ_PAUSE, '0, '0, 1'b0);
      else if (r < 89 && !wide) send_item(rspv_pkg::REQ_STOP, '0, '0, 1'b0);
      else if (r < 95) send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b1);
      else send_item(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                     16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 6));   // below the minimum pitch
      1: return 32'd65536;
      2: return 32'hFFFF_FFFF;
      3: return 32'd32768;
      default: return 32'($urandom_range(1, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: one mono frame, two outputs.
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);            // not playing: zeros
    send_item(rspv_pkg::REQ_WRITE, 16'h0000, 16'h7FFF, 1'b0);
    send_item(rspv_pkg::REQ_WRITE, 16'hFFFF, 16'h8000, 1'b1);
    send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b0);
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);            // last frame, fraction dropped
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);            // past clip end: stops
    send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b1);
    send_item(rspv_pkg::REQ_RENDER, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(rspv_pkg::REQ_PAUSE, '0, '0, 1'b0);
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);            // paused: zeros
    send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b0);
    send_item(rspv_pkg::REQ_STOP, '0, '0, 1'b0);
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);
    send_item(REQ_SPARE_FIRST, 16'h1234, 16'h5678, 1'b1);     // ignored codes
    send_item(REQ_SPARE_MID, '0, '0, 1'b0);
    send_item(REQ_SPARE_LAST, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(rspv_pkg::REQ_WRITE, 16'h0000, 16'h8000, 1'b0);
    send_item(rspv_pkg::REQ_PLAY, '0, '0, 1'b1);
    send_item(rspv_pkg::REQ_RENDER, '0, '0, 1'b0);

    // Extremes: saturating gains, minimum step, single output channel.
    run_phase(17'd3, 4'd2, 32'd0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 4'd1, 30, 1'b0);
    // Eight channels mixed to mono, loud left gain, zero right gain, all eight outputs.
    hold_request = 1;
    run_phase(17'd4, 4'd8, 32'd98304, 1'b1, 1'b1, 16'hFFFF, 16'd0, 4'd8, 30, 1'b0);
    // Oversized channel and output counts, huge step.
    run_phase(17'd2, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 16'hFFFF, 4'd15, 20, 1'b0);
    // Empty clip stops the voice on render.
    run_phase(17'd0, 4'd1, 32'd65536, 1'b1, 1'b0, 16'd4096, 16'd4096, 4'd0, 12, 1'b0);
    // Clip length beyond the maximum saturates; full-width channel count.
    run_phase(17'h1FFFF, 4'd8, 32'd65536, 1'b0, 1'b1, 16'd4096, 16'd8192, 4'd3, 8, 1'b1);
    run_phase(17'd65536, 4'd1, 32'd65536, 1'b1, 1'b0, 16'hFFFF, 16'h8000, 4'd2, 8, 1'b1);
    for (int p = 0; p < 2; p++)
      run_phase(17'($urandom_range(1, 12)),
                ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8)),
                pick_step(), 1'($urandom), 1'($urandom), pick_gain(), pick_gain(),
                4'($urandom_range(0, 15)), 12, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("resampling_sample_playback_voice regression: pass");
    end else begin
      $display("resampling_sample_playback_voice regression: fail");
    end
    $finish;
  end
endmodule
